// ----- src/tcpc_pkg.sv -----
// Shared types, constants and helpers for the TCP segment parser and checksum block.
package tcpc_pkg;

  localparam int unsigned HDR_BYTES   = 20;
  localparam int unsigned MAX_PAYLOAD = 1460;
  localparam int unsigned PLEN_W      = 11;
  localparam int unsigned APB_AW      = 3;
  localparam logic [15:0] PROTO_TCP   = 16'd6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BAD_HLEN = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // Snapshot of one finished segment, handed from the byte stage to the finish stage
  typedef struct packed {
    logic [15:0]                 sum;   // data sum, odd byte already padded
    logic [15:0]                 cnt;   // segment length mod 2^16
    logic                        ovf;   // length wrapped
    logic [HDR_BYTES-1:0][7:0]   hdr;   // hdr[i] is header byte i
  } seg_fin_t;

  typedef struct packed {
    logic [15:0]       source_port;
    logic [15:0]       destination_port;
    logic [31:0]       sequence_number;
    logic [31:0]       acknowledge_number;
    logic [3:0]        header_words;
    logic [7:0]        flag_bits;
    logic [15:0]       window_size;
    logic [15:0]       received_checksum;
    logic [15:0]       urgent_pointer;
    logic [PLEN_W-1:0] payload_length;
    logic [15:0]       computed_sum;
    status_e           status;
  } tcp_result_t;

  // Ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- src/tcpc_cfg.sv -----
// APB register file for the pseudo-header addresses, with their precomputed sum.
module tcpc_cfg import tcpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [15:0]       addr_sum_o
);

  localparam logic REG_SRC = 1'b0;
  localparam logic REG_DST = 1'b1;

  logic [31:0] src_q, dst_q;
  logic [15:0] addr_sum_q, addr_sum_d;
  logic        wr_en;
  logic [18:0] raw;
  logic [16:0] fold1;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
      dst_q <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SRC: src_q <= pwdata;
        REG_DST: dst_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SRC: prdata = src_q;
      REG_DST: prdata = dst_q;
      default: prdata = '0;
    endcase
  end

  // address halves plus protocol, folded twice
  always_comb begin
    raw = 19'(src_q[31:16]) + 19'(src_q[15:0]) + 19'(dst_q[31:16]) +
          19'(dst_q[15:0]) + 19'(PROTO_TCP);
    fold1 = {1'b0, raw[15:0]} + {14'd0, raw[18:16]};
    addr_sum_d = fold1[15:0] + {15'd0, fold1[16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) addr_sum_q <= '0;
    else         addr_sum_q <= addr_sum_d;
  end

  assign addr_sum_o = addr_sum_q;

endmodule

// ----- src/tcpc_seg.sv -----
// Per-byte segment state: count, running sum, header capture and end-of-segment snapshot.
module tcpc_seg import tcpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     acc_i,      // byte transaction this cycle
  input  logic [7:0] byte_i,
  input  logic     last_i,
  input  logic     fin_take_i, // finish stage takes the snapshot
  output logic     fin_vld_o,
  output seg_fin_t fin_o
);

  logic [15:0]               cnt_q, cnt_nx;
  logic                      ovf_q, ovf_nx;
  logic [15:0]               run_q, sum_nx, word;
  logic [7:0]                pend_q;
  logic [HDR_BYTES-1:0][7:0] hdr_q, hdr_nx;
  logic                      cap;
  logic                      fin_vld_q;
  seg_fin_t                  fin_q;

  assign cap    = !ovf_q && (cnt_q < 16'(HDR_BYTES));
  assign cnt_nx = cnt_q + 16'd1;
  assign ovf_nx = ovf_q | (cnt_nx == 16'd0);
  // odd position closes a word; even position is a high byte padded with zero
  assign word   = cnt_q[0] ? {pend_q, byte_i} : {byte_i, 8'h00};
  assign sum_nx = oc_add(run_q, word);

  always_comb begin
    for (int i = 0; i < int'(HDR_BYTES); i++) begin
      hdr_nx[i] = (cap && cnt_q == 16'(i)) ? byte_i : hdr_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      run_q  <= '0;
      pend_q <= '0;
      hdr_q  <= '0;
    end else if (acc_i) begin
      if (last_i) begin
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
        run_q  <= '0;
        pend_q <= '0;
        hdr_q  <= '0;
      end else begin
        cnt_q <= cnt_nx;
        ovf_q <= ovf_nx;
        hdr_q <= hdr_nx;
        if (cnt_q[0]) run_q  <= sum_nx;
        else          pend_q <= byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                fin_vld_q <= 1'b0;
    else if (acc_i && last_i)   fin_vld_q <= 1'b1;
    else if (fin_take_i)        fin_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && last_i) begin
      fin_q.sum <= sum_nx;
      fin_q.cnt <= cnt_nx;
      fin_q.ovf <= ovf_nx;
      fin_q.hdr <= hdr_nx;
    end
  end

  assign fin_vld_o = fin_vld_q;
  assign fin_o     = fin_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && last_i |=> cnt_q == 16'd0 && !ovf_q && run_q == 16'd0)
    else $error("segment state not cleared after last byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !last_i |=> cnt_q == $past(cnt_nx))
    else $error("byte count did not advance");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q && !fin_take_i && !acc_i |=> fin_vld_q && $stable(fin_q))
    else $error("pending snapshot lost or changed");

endmodule

// ----- src/tcpc_finish.sv -----
// Final checksum fold, header field extraction, status and the result register.
module tcpc_finish import tcpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fin_vld_i,
  input  seg_fin_t    fin_i,
  input  logic [15:0] addr_sum_i,
  input  logic        out_ready_i,
  output logic        fin_take_o,
  output logic        out_vld_o,
  output tcp_result_t out_o
);

  logic        out_vld_q;
  tcp_result_t out_q, res;
  logic [17:0] raw;
  logic [16:0] fold1;
  logic [15:0] total;
  logic [5:0]  hlen;
  logic [15:0] diff;

  assign fin_take_o = fin_vld_i && (!out_vld_q || out_ready_i);

  always_comb begin
    raw   = 18'(fin_i.sum) + 18'(addr_sum_i) + 18'(fin_i.cnt);
    fold1 = {1'b0, raw[15:0]} + {15'd0, raw[17:16]};
    total = fold1[15:0] + {15'd0, fold1[16]};

    hlen = {fin_i.hdr[12][7:4], 2'b00};
    diff = fin_i.cnt - 16'(hlen);

    res.source_port        = {fin_i.hdr[0], fin_i.hdr[1]};
    res.destination_port   = {fin_i.hdr[2], fin_i.hdr[3]};
    res.sequence_number    = {fin_i.hdr[4], fin_i.hdr[5], fin_i.hdr[6], fin_i.hdr[7]};
    res.acknowledge_number = {fin_i.hdr[8], fin_i.hdr[9], fin_i.hdr[10], fin_i.hdr[11]};
    res.header_words       = fin_i.hdr[12][7:4];
    res.flag_bits          = fin_i.hdr[13];
    res.window_size        = {fin_i.hdr[14], fin_i.hdr[15]};
    res.received_checksum  = {fin_i.hdr[16], fin_i.hdr[17]};
    res.urgent_pointer     = {fin_i.hdr[18], fin_i.hdr[19]};
    res.computed_sum       = ~total;
    res.payload_length     = '0;

    if (!fin_i.ovf && fin_i.cnt < 16'(HDR_BYTES)) begin
      res.status = ST_SHORT;
    end else if (fin_i.ovf) begin
      res.status = ST_TOO_LONG;
    end else if (hlen < 6'(HDR_BYTES) || 16'(hlen) > fin_i.cnt) begin
      res.status = ST_BAD_HLEN;
    end else if (diff > 16'(MAX_PAYLOAD)) begin
      res.status = ST_TOO_LONG;
    end else begin
      res.status         = ST_OK;
      res.payload_length = diff[PLEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_vld_q <= 1'b0;
    else if (fin_take_o)  out_vld_q <= 1'b1;
    else if (out_ready_i) out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (fin_take_o) out_q <= res;
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

  a_ok_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == ST_OK |->
      out_q.payload_length <= PLEN_W'(MAX_PAYLOAD) && out_q.header_words >= 4'd5)
    else $error("ok result with impossible lengths");

  a_err_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status != ST_OK |-> out_q.payload_length == '0)
    else $error("error result carries a payload length");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && !$past(fin_take_o))
    else $error("result register overwritten while stalled");

endmodule

// ----- src/tcp_segment_parse_and_checksum_top.sv -----
// Top level of the TCP segment parser with Internet checksum.
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid/s_axis_tready    one segment byte, tlast on final byte
//  m_axis    out  m_axis_tvalid/m_axis_tready    parsed header, lengths, checksum, status
//  apb       in   psel/penable/pwrite, pready=1  source / destination IPv4 address
//
// One byte is taken per clock while s_axis_tready is high; each segment passes
// through the byte stage (count, sum, header capture) into the snapshot register,
// then the finish stage (pseudo-header fold, status) into the result register.
// Reset clears the addresses and the segment state; no clearing pass is needed.
// A stalled result holds the result register; the snapshot register behind it
// still takes one more finished segment, and only a last byte that finds both
// full stalls the input.
module tcp_segment_parse_and_checksum_top import tcpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [15:0] source_port, [31:16] destination_port, [63:32] sequence_number,
  // [95:64] acknowledge_number, [99:96] header_words, [107:100] flag_bits,
  // [123:108] window_size, [139:124] received_checksum, [155:140] urgent_pointer,
  // [166:156] payload_length, [182:167] computed_sum, [183] zero
  output logic [183:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser,   // [1:0] status
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        acc;
  logic        fin_vld, fin_take;
  seg_fin_t    fin;
  logic [15:0] addr_sum;
  tcp_result_t res;

  // a last byte needs room in the snapshot register; other bytes always go
  assign s_axis_tready = !fin_vld || fin_take || !s_axis_tlast;
  assign acc           = s_axis_tvalid && s_axis_tready;

  tcpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .addr_sum_o (addr_sum)
  );

  tcpc_seg u_seg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .byte_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .fin_take_i (fin_take),
    .fin_vld_o  (fin_vld),
    .fin_o      (fin)
  );

  tcpc_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_vld_i   (fin_vld),
    .fin_i       (fin),
    .addr_sum_i  (addr_sum),
    .out_ready_i (m_axis_tready),
    .fin_take_o  (fin_take),
    .out_vld_o   (m_axis_tvalid),
    .out_o       (res)
  );

  assign m_axis_tdata = {1'b0,
                         res.computed_sum,
                         res.payload_length,
                         res.urgent_pointer,
                         res.received_checksum,
                         res.window_size,
                         res.flag_bits,
                         res.header_words,
                         res.acknowledge_number,
                         res.sequence_number,
                         res.destination_port,
                         res.source_port};
  assign m_axis_tuser = res.status;

endmodule
